FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the sRGB encoder.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPLIES(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: hw/rtl/lsrgb_pkg.sv
// Shared constants and elaboration-time threshold functions for the sRGB encoder.
// No dependencies; used by lsrgb_channel_enc and linear_to_srgb8_encoder_unit.
`timescale 1ns / 1ps

package lsrgb_pkg;

  localparam int IN_W          = 18;
  localparam int CODE_W        = 8;
  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_CODES     = 256;

  localparam logic [63:0] LIN_LIMIT = 64'd20629467360;
  localparam logic [63:0] LIN_DEN   = 64'd658920;
  localparam logic [63:0] CURVE_DEN = 64'd538050;
  localparam logic [63:0] Q30_ONE   = 64'd1 << 30;

  // Fifth power in Q30, each product truncated.
  function automatic logic [63:0] pow5_q30(logic [63:0] r);
    logic [63:0] p;
    p = r;
    for (int i = 0; i < 4; i++) begin
      p = (p * r) >> 30;
    end
    return p;
  endfunction

  // Decision threshold for code k (1..255) in Q32 linear light.
  function automatic logic [63:0] thresh_q32(int unsigned k);
    logic [63:0] odd;
    logic [63:0] num;
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] t;
    odd = 64'(2 * k - 1);
    if (odd * 64'd1000000000 <= LIN_LIMIT) begin
      num = (odd * 64'd100) << 32;
      t   = (num + (LIN_DEN - 64'd1)) / LIN_DEN;
    end else begin
      num = (odd * 64'd1000 + 64'd28050) << 30;
      u   = (num + (CURVE_DEN >> 1)) / CURVE_DEN;
      u2  = (u * u) >> 30;
      lo  = 64'd0;
      hi  = Q30_ONE;
      // Largest fifth root not above u2; 32 halvings cover the Q30 range.
      for (int i = 0; i < 32; i++) begin
        if (lo < hi) begin
          mid = lo + ((hi - lo + 64'd1) >> 1);
          if (pow5_q30(mid) <= u2) begin
            lo = mid;
          end else begin
            hi = mid - 64'd1;
          end
        end
      end
      t = ((u2 * lo) >> 30) << 2;
    end
    return t;
  endfunction

  // Threshold moved into the input's fixed-point scale, rounded up so that
  // a plain compare on the clamped input matches the Q32 compare exactly.
  function automatic logic [63:0] thresh_in(int unsigned k, int unsigned frac);
    logic [63:0] step;
    step = 64'd1 << (32 - frac);
    return (thresh_q32(k) + step - 64'd1) >> (32 - frac);
  endfunction

endpackage

FILE: hw/rtl/lsrgb_channel_enc.sv
// One channel of the sRGB encoder: clamp, threshold compare bank and
// thermometer-to-binary decode. Depends on lsrgb_pkg.
`timescale 1ns / 1ps

module lsrgb_channel_enc #(
  parameter int FRAC_BITS = lsrgb_pkg::FRAC_BITS_DEF
) (
  input  logic [lsrgb_pkg::IN_W-1:0]   lin_i,
  output logic [lsrgb_pkg::CODE_W-1:0] code_o
);

  localparam int IN_W  = lsrgb_pkg::IN_W;
  localparam int VW    = FRAC_BITS + 1;
  localparam int XW    = (VW > IN_W - 1) ? VW : IN_W - 1;
  localparam int NCODE = lsrgb_pkg::NUM_CODES;
  localparam int TW    = $clog2(NCODE + 1);

  logic [XW-1:0]    mag;
  logic [XW-1:0]    one_x;
  logic [XW-1:0]    clamped;
  logic [VW-1:0]    val;
  logic [NCODE:0]   therm;
  logic [lsrgb_pkg::CODE_W-1:0] code_c;

  assign mag   = XW'(lin_i[IN_W-2:0]);
  assign one_x = XW'(1) << FRAC_BITS;

  always_comb begin
    if (lin_i[IN_W-1]) begin
      clamped = '0;
    end else if (mag > one_x) begin
      clamped = one_x;
    end else begin
      clamped = mag;
    end
  end

  // The clamped value never exceeds one, so it fits FRAC_BITS + 1 bits.
  assign val = clamped[VW-1:0];

  // therm[k] is set when the value reaches threshold k; the thresholds rise
  // with k, so the set bits form an unbroken run from the bottom.
  assign therm[0]     = 1'b1;
  assign therm[NCODE] = 1'b0;

  for (genvar k = 1; k < NCODE; k++) begin : g_cmp
    localparam logic [63:0] T64 = lsrgb_pkg::thresh_in(k, FRAC_BITS);
    localparam logic [VW-1:0] TK = T64[VW-1:0];
    assign therm[k] = (val >= TK);
  end

  // Bit j of the code is set when the run ends inside a block of 2^j codes
  // with an odd block number.
  always_comb begin
    for (int j = 0; j < lsrgb_pkg::CODE_W; j++) begin
      code_c[j] = 1'b0;
      for (int m = 1; (m << j) < NCODE; m += 2) begin
        code_c[j] = code_c[j] | (therm[TW'(m << j)] & ~therm[TW'((m + 1) << j)]);
      end
    end
  end

  assign code_o = code_c;

endmodule

FILE: hw/rtl/linear_to_srgb8_encoder_unit.sv
// Linear RGB to 8-bit sRGB encoder: top level with input and result registers.
// Depends on lsrgb_pkg, lsrgb_channel_enc and assert_macros.svh.
// Pipeline: the input register feeds the result register directly; a pixel moves
// on only when the result register is empty or its contents leave.
// Throughput: one pixel per cycle while the output is not stalled; each channel is one
// compare bank and decode between the input register and the result register.
`timescale 1ns / 1ps
// Reset: synchronous, active low; clears both valid flags only.

`include "assert_macros.svh"

module linear_to_srgb8_encoder_unit #(
  parameter int FRAC_BITS = lsrgb_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [lsrgb_pkg::IN_W-1:0]   in_linear_red,
  input  logic signed [lsrgb_pkg::IN_W-1:0]   in_linear_green,
  input  logic signed [lsrgb_pkg::IN_W-1:0]   in_linear_blue,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [lsrgb_pkg::CODE_W-1:0]        out_code_red,
  output logic [lsrgb_pkg::CODE_W-1:0]        out_code_green,
  output logic [lsrgb_pkg::CODE_W-1:0]        out_code_blue
);

  localparam int IN_W   = lsrgb_pkg::IN_W;
  localparam int CODE_W = lsrgb_pkg::CODE_W;

  logic              s1_valid_r;
  logic              s1_valid_nxt;
  logic [IN_W-1:0]   s1_red_r;
  logic [IN_W-1:0]   s1_green_r;
  logic [IN_W-1:0]   s1_blue_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [CODE_W-1:0] code_red_r;
  logic [CODE_W-1:0] code_green_r;
  logic [CODE_W-1:0] code_blue_r;
  logic [CODE_W-1:0] red_c;
  logic [CODE_W-1:0] green_c;
  logic [CODE_W-1:0] blue_c;
  logic              s2_ready;
  logic              in_xfer;
  logic              s1_move;

  // The result register takes a new pixel whenever it is empty or its
  // contents leave in this cycle.
  assign s2_ready = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s2_ready;
  assign in_xfer  = in_valid && in_ready;
  assign s1_move  = s1_valid_r && s2_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s2_ready) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_red_r   <= in_linear_red;
      s1_green_r <= in_linear_green;
      s1_blue_r  <= in_linear_blue;
    end
  end

  lsrgb_channel_enc #(.FRAC_BITS(FRAC_BITS)) u_enc_red (
    .lin_i  (s1_red_r),
    .code_o (red_c)
  );

  lsrgb_channel_enc #(.FRAC_BITS(FRAC_BITS)) u_enc_green (
    .lin_i  (s1_green_r),
    .code_o (green_c)
  );

  lsrgb_channel_enc #(.FRAC_BITS(FRAC_BITS)) u_enc_blue (
    .lin_i  (s1_blue_r),
    .code_o (blue_c)
  );

  always_ff @(posedge clk) begin
    if (s1_move) begin
      code_red_r   <= red_c;
      code_green_r <= green_c;
      code_blue_r  <= blue_c;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_code_red   = code_red_r;
  assign out_code_green = code_green_r;
  assign out_code_blue  = code_blue_r;

  // A full pipeline with a stalled output must not take another pixel.
  `ASSERT_IMPLIES(a_no_overwrite, clk, rst_n, s1_valid_r && out_valid_r && !out_ready, !in_ready)
  // A pixel that leaves the input register shows up as a result next cycle.
  `ASSERT_NEXT(a_stage_advance, clk, rst_n, s1_move, out_valid_r)
  // A negative red channel is encoded as code zero.
  `ASSERT_NEXT(a_neg_red_zero, clk, rst_n, s1_move && s1_red_r[IN_W-1], out_code_red == '0)

endmodule

FILE: tb/sv/tb_linear_to_srgb8_encoder_unit.sv
// Self-checking testbench for linear_to_srgb8_encoder_unit, the sRGB 8-bit encoder.
// Depends on lsrgb_pkg for port widths; a scoreboard class predicts the codes.
`timescale 1ns / 1ps

module tb_linear_to_srgb8_encoder_unit;

  localparam int CH_W         = lsrgb_pkg::IN_W;
  localparam int CODE_BITS    = lsrgb_pkg::CODE_W;
  localparam int FRAC         = lsrgb_pkg::FRAC_BITS_DEF;
  localparam int UNITY        = 1 << FRAC;
  localparam int Q32_SHIFT    = 32 - FRAC;
  localparam int NUM_STEPS    = 255;
  localparam int RANDOM_ITEMS = 550;
  localparam int LATENCY      = 2;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_REPORTS  = 10;

  // Knee of the curve and the divisors of the threshold formulas.
  localparam longint unsigned LIN_KNEE  = 64'd20629467360;
  localparam longint unsigned LIN_DIV   = 64'd658920;
  localparam longint unsigned CURVE_DIV = 64'd538050;
  localparam longint unsigned Q30_UNIT  = 64'd1 << 30;

  typedef struct packed {
    logic [CODE_BITS-1:0] red;
    logic [CODE_BITS-1:0] green;
    logic [CODE_BITS-1:0] blue;
  } srgb_codes_t;

  typedef struct {
    logic signed [CH_W-1:0] red;
    logic signed [CH_W-1:0] green;
    logic signed [CH_W-1:0] blue;
  } linear_pixel_t;

  typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_PERIODIC, RX_LONG} rx_mode_t;

  class srgb_code_board;
    longint unsigned thr_q32 [1:NUM_STEPS];
    srgb_codes_t     pending_codes [$];
    int unsigned     errors;
    int unsigned     reports;
    int unsigned     noted;
    int unsigned     checked;
    int unsigned     clamped_low;
    int unsigned     clamped_high;

    // Decision thresholds in Q32: code k is reached when the clamped value
    // is at or above threshold k.
    function new();
      longint unsigned odd;
      longint unsigned u;
      longint unsigned u2;
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned mid;
      longint unsigned p;
      for (int k = 1; k <= NUM_STEPS; k++) begin
        odd = 2 * k - 1;
        if (odd * 64'd1000000000 <= LIN_KNEE) begin
          thr_q32[k] = (((odd * 64'd100) << 32) + (LIN_DIV - 64'd1)) / LIN_DIV;
        end else begin
          u  = (((odd * 64'd1000 + 64'd28050) << 30) + (CURVE_DIV >> 1)) / CURVE_DIV;
          u2 = (u * u) >> 30;
          lo = 0;
          hi = Q30_UNIT;
          // Largest r whose truncated Q30 fifth power stays at or below u2.
          while (lo < hi) begin
            mid = lo + (hi - lo + 64'd1) / 2;
            p = mid;
            repeat (4) p = (p * mid) >> 30;
            if (p <= u2) begin
              lo = mid;
            end else begin
              hi = mid - 64'd1;
            end
          end
          thr_q32[k] = ((u2 * lo) >> 30) << 2;
        end
      end
      errors = 0;
      reports = 0;
      noted = 0;
      checked = 0;
      clamped_low = 0;
      clamped_high = 0;
    endfunction

    // Smallest input level that reaches threshold k.
    function longint unsigned thr_in(int k);
      return (thr_q32[k] + (64'd1 << Q32_SHIFT) - 64'd1) >> Q32_SHIFT;
    endfunction

    function logic [CODE_BITS-1:0] encode(logic signed [CH_W-1:0] x);
      longint unsigned v;
      longint unsigned x32;
      int unsigned n;
      if (x < 0) begin
        v = 0;
        clamped_low++;
      end else if (x > UNITY) begin
        v = UNITY;
        clamped_high++;
      end else begin
        v = x;
      end
      x32 = v << Q32_SHIFT;
      n = 0;
      for (int k = 1; k <= NUM_STEPS; k++) begin
        if (x32 >= thr_q32[k]) n++;
      end
      return n[CODE_BITS-1:0];
    endfunction

    function void note_pixel(logic signed [CH_W-1:0] r, logic signed [CH_W-1:0] g,
                             logic signed [CH_W-1:0] b);
      srgb_codes_t c;
      c.red   = encode(r);
      c.green = encode(g);
      c.blue  = encode(b);
      pending_codes.push_back(c);
      noted++;
    endfunction

    function void check_codes(logic [CODE_BITS-1:0] r, logic [CODE_BITS-1:0] g,
                              logic [CODE_BITS-1:0] b);
      srgb_codes_t want;
      logic [CODE_BITS-1:0] exp_ch [3];
      logic [CODE_BITS-1:0] got_ch [3];
      string names [3];
      checked++;
      if (pending_codes.size() == 0) begin
        errors++;
        if (reports < MAX_REPORTS) begin
          reports++;
          $display("ERROR: result %0d/%0d/%0d arrived with no pixel outstanding", r, g, b);
        end
        return;
      end
      want = pending_codes.pop_front();
      exp_ch = '{want.red, want.green, want.blue};
      got_ch = '{r, g, b};
      names  = '{"red", "green", "blue"};
      foreach (exp_ch[i]) begin
        if (exp_ch[i] !== got_ch[i]) begin
          errors++;
          if (reports < MAX_REPORTS) begin
            reports++;
            $display("ERROR: result %0d, code_%s expected %0d, got %0d",
                     checked, names[i], exp_ch[i], got_ch[i]);
          end
        end
      end
    endfunction

    function int unsigned pending();
      return pending_codes.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic signed [CH_W-1:0] in_linear_red;
  logic signed [CH_W-1:0] in_linear_green;
  logic signed [CH_W-1:0] in_linear_blue;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [CODE_BITS-1:0]   out_code_red;
  logic [CODE_BITS-1:0]   out_code_green;
  logic [CODE_BITS-1:0]   out_code_blue;

  srgb_code_board board = new();
  int unsigned    cycles = 0;
  int unsigned    edge_values;
  int unsigned    ready_tick = 0;
  rx_mode_t       rx_mode = RX_ALWAYS;

  linear_to_srgb8_encoder_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_linear_red   (in_linear_red),
    .in_linear_green (in_linear_green),
    .in_linear_blue  (in_linear_blue),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_code_red    (out_code_red),
    .out_code_green  (out_code_green),
    .out_code_blue   (out_code_blue)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Both transfers are taken from the values that held just before the edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        board.note_pixel(in_linear_red, in_linear_green, in_linear_blue);
      end
      if (out_valid && out_ready) begin
        board.check_codes(out_code_red, out_code_green, out_code_blue);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("ERROR: run exceeded %0d cycles", CYCLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver back-pressure: one of four stall patterns, redrawn at random as ready_tick advances.
  always @(negedge clk) begin
    ready_tick <= ready_tick + 1;
    if (ready_tick % 100 == 99) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
    end
    case (rx_mode)
      RX_ALWAYS:   out_ready <= 1'b1;
      RX_COIN:     out_ready <= 1'($urandom_range(0, 1));
      RX_PERIODIC: out_ready <= (ready_tick % 8) >= 3;
      default:     out_ready <= (ready_tick % 32) >= 24;
    endcase
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_pixel(input logic signed [CH_W-1:0] r, input logic signed [CH_W-1:0] g,
                            input logic signed [CH_W-1:0] b);
    in_valid        <= 1'b1;
    in_linear_red   <= r;
    in_linear_green <= g;
    in_linear_blue  <= b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic idle_for(input int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  // Mostly in-range levels, with threshold edges, the linear toe and raw noise.
  function automatic logic signed [CH_W-1:0] random_level();
    int unsigned sel;
    int          k;
    sel = $urandom_range(0, 99);
    if (sel < 55) begin
      return CH_W'($urandom_range(0, UNITY));
    end else if (sel < 70) begin
      k = $urandom_range(1, NUM_STEPS);
      edge_values++;
      return CH_W'(board.thr_in(k) - 64'($urandom_range(0, 1)));
    end else if (sel < 85) begin
      return CH_W'($urandom_range(0, 300));
    end
    return CH_W'($urandom_range(0, (1 << CH_W) - 1));
  endfunction

  initial begin
    linear_pixel_t directed [$];
    int            knots [8];
    int unsigned   burst_left;
    int unsigned   gap;
    edge_values = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_linear_red = '0;
    in_linear_green = '0;
    in_linear_blue = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Zero, both ends of the field, unity and its neighbors, alternating bits.
    directed.push_back('{18'sd0, 18'sd0, 18'sd0});
    directed.push_back('{-18'sd131072, 18'sd131071, CH_W'(UNITY)});
    directed.push_back('{-18'sd1, 18'sd1, CH_W'(UNITY - 1)});
    directed.push_back('{CH_W'(UNITY + 1), -CH_W'(UNITY), 18'sd2});
    directed.push_back('{18'sh15555, 18'sh2AAAA, 18'sh3FFFF});
    directed.push_back('{18'sh2AAAA, 18'sh15555, 18'sh0FFFF});
    // Exactly on a threshold and one step below, across the knee of the curve.
    knots = '{1, 2, 10, 11, 12, 128, 254, 255};
    foreach (knots[j]) begin
      directed.push_back('{CH_W'(board.thr_in(knots[j])),
                           CH_W'(board.thr_in(knots[j]) - 1),
                           CH_W'(board.thr_in(knots[(j + 3) % 8]))});
      edge_values += 3;
    end
    foreach (directed[j]) begin
      send_pixel(directed[j].red, directed[j].green, directed[j].blue);
    end
    wait_drained();

    burst_left = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) wait_drained();
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap != 0) idle_for(gap);
      end
      send_pixel(random_level(), random_level(), random_level());
      burst_left--;
    end
    wait_drained();
    repeat (4 * LATENCY) @(posedge clk);

    $display("Encoded %0d pixels and checked %0d results in %0d cycles.",
             board.noted, board.checked, cycles);
    $display("Channels clamped low: %0d, clamped high: %0d, driven on a threshold edge: %0d.",
             board.clamped_low, board.clamped_high, edge_values);
    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches in total", board.errors);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
